// ----- rtl/core/dma_ring_consumer_window_assert.svh -----
// Assertion macros for the DMA ring consumer window block.
`ifndef DMA_RING_CONSUMER_WINDOW_ASSERT_SVH
`define DMA_RING_CONSUMER_WINDOW_ASSERT_SVH
`ifndef SYNTH
`define DRCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DRCW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DRCW_ASSERT(lbl, prop, msg)
`define DRCW_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- rtl/core/drcw_pkg.sv -----
// Package: widths, codes and shared types of the DMA ring consumer window.
`default_nettype none
package drcw_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int RING_W      = 25;
  localparam int SPLICE_W    = 15;
  localparam int HEAD_W      = 14;
  localparam int CFG_IDX_W   = 2;

  localparam logic [RING_W-1:0]   RING_RESET   = 25'h1000000;
  localparam logic [SPLICE_W-1:0] SPLICE_RESET = 15'd8192;

  localparam logic [1:0] OP_POLL  = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RING_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPLICE_BYTES = 2'd1;

  typedef enum logic [2:0] {
    ST_DATA       = 3'd0,
    ST_NONE       = 3'd1,
    ST_RESET      = 3'd2,
    ST_STALLED    = 3'd3,
    ST_OVERFLOW   = 3'd4,
    ST_RANGE      = 3'd5,
    ST_DONE       = 3'd6,
    ST_MISALIGNED = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0]             op;
    logic [OFFSET_BITS-1:0] producer_offset;
    logic                   message_flag;
    logic                   reset_flag;
    logic                   stalled_flag;
    logic                   overflow_flag;
    logic [RING_W-1:0]      ack_bytes;
  } item_t;

  typedef struct packed {
    status_t                status;
    logic                   from_splice;
    logic [OFFSET_BITS-1:0] window_offset;
    logic [RING_W-1:0]      window_bytes;
    logic [HEAD_W-1:0]      head_bytes;
    logic [SPLICE_W-1:0]    tail_bytes;
  } result_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] cons;
    logic [OFFSET_BITS-1:0] last_off;
    logic [RING_W-1:0]      last_bytes;
  } ring_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/drcw_in_if.sv -----
// Input channel interface: poll, ack and clear words.
`default_nettype none
interface drcw_in_if;
  import drcw_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             op;
  logic [OFFSET_BITS-1:0] producer_offset;
  logic                   message_flag;
  logic                   reset_flag;
  logic                   stalled_flag;
  logic                   overflow_flag;
  logic [RING_W-1:0]      ack_bytes;

  modport source (output valid, op, producer_offset, message_flag, reset_flag,
                  stalled_flag, overflow_flag, ack_bytes, input ready);
  modport sink (input valid, op, producer_offset, message_flag, reset_flag,
                stalled_flag, overflow_flag, ack_bytes, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/drcw_out_if.sv -----
// Result channel interface: status and readable window words.
`default_nettype none
interface drcw_out_if;
  import drcw_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [2:0]             status;
  logic                   from_splice;
  logic [OFFSET_BITS-1:0] window_offset;
  logic [RING_W-1:0]      window_bytes;
  logic [HEAD_W-1:0]      head_bytes;
  logic [SPLICE_W-1:0]    tail_bytes;

  modport source (output valid, status, from_splice, window_offset, window_bytes,
                  head_bytes, tail_bytes, input ready);
  modport sink (input valid, status, from_splice, window_offset, window_bytes,
                head_bytes, tail_bytes, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/drcw_step.sv -----
// Per-word datapath: window/splice computation, ack advance and next ring state.
`default_nettype none
module drcw_step (
  input  drcw_pkg::item_t              item,
  input  drcw_pkg::ring_state_t        st,
  input  logic [drcw_pkg::RING_W-1:0]   ring_bytes,
  input  logic [drcw_pkg::SPLICE_W-1:0] splice_bytes,
  output drcw_pkg::result_t            res,
  output drcw_pkg::ring_state_t        st_nxt
);
  import drcw_pkg::*;

  logic                   prod_ge;
  logic [OFFSET_BITS-1:0] diff_lin;
  logic [RING_W-1:0]      cons_x;
  logic [RING_W-1:0]      to_end;
  logic                   range_err;
  logic                   splice_hit;
  logic [SPLICE_W-1:0]    room;
  logic [SPLICE_W-1:0]    tail;
  logic [SPLICE_W-1:0]    spl_count;
  logic [RING_W-1:0]      count_raw;
  logic [RING_W-1:0]      count_fl;

  logic                   misaligned;
  logic [RING_W-1:0]      n_clamp;
  logic [RING_W:0]        sum;
  logic [RING_W:0]        sum_w;
  logic [RING_W:0]        ring_x;

  // poll path
  always_comb begin
    cons_x     = {1'b0, st.cons};
    prod_ge    = item.producer_offset >= st.cons;
    diff_lin   = item.producer_offset - st.cons;
    to_end     = ring_bytes - cons_x;
    range_err  = ring_bytes <= cons_x;
    splice_hit = (st.last_off == st.cons) &&
                 (to_end < {{(RING_W-SPLICE_W){1'b0}}, splice_bytes});
    room       = splice_bytes - to_end[SPLICE_W-1:0];
    tail       = ({{(OFFSET_BITS-SPLICE_W){1'b0}}, room} < item.producer_offset) ?
                 room : item.producer_offset[SPLICE_W-1:0];
    // head + tail never exceeds the splice capacity
    spl_count  = to_end[SPLICE_W-1:0] + tail;
    if (prod_ge) begin
      count_raw = {1'b0, diff_lin};
    end else if (splice_hit) begin
      count_raw = {{(RING_W-SPLICE_W){1'b0}}, spl_count};
    end else begin
      count_raw = to_end;
    end
    count_fl = {count_raw[RING_W-1:2], 2'b00};
  end

  // ack path: clamp, add, one compare-subtract wrap
  always_comb begin
    misaligned = item.ack_bytes[1:0] != 2'b00;
    n_clamp    = (item.ack_bytes > st.last_bytes) ? st.last_bytes : item.ack_bytes;
    sum        = {2'b00, st.cons} + {1'b0, n_clamp};
    ring_x     = {1'b0, ring_bytes};
    sum_w      = (sum >= ring_x) ? (sum - ring_x) : sum;
  end

  always_comb begin
    res        = '0;
    res.status = ST_RANGE;
    st_nxt     = st;
    unique case (item.op)
      OP_POLL: begin
        if (!item.message_flag) begin
          priority if (item.reset_flag) res.status = ST_RESET;
          else if (item.stalled_flag)   res.status = ST_STALLED;
          else if (item.overflow_flag)  res.status = ST_OVERFLOW;
          else                          res.status = ST_NONE;
        end else if (!prod_ge && range_err) begin
          res.status = ST_RANGE;
        end else if (count_fl == '0) begin
          res.status = ST_NONE;
        end else begin
          res.status        = ST_DATA;
          res.window_offset = st.cons;
          res.window_bytes  = count_fl;
          if (!prod_ge && splice_hit) begin
            res.from_splice = 1'b1;
            res.head_bytes  = to_end[HEAD_W-1:0];
            res.tail_bytes  = tail;
          end
          st_nxt.last_off   = st.cons;
          st_nxt.last_bytes = count_fl;
        end
      end
      OP_ACK: begin
        if (misaligned) begin
          res.status = ST_MISALIGNED;
        end else begin
          res.status = ST_DONE;
          if (item.ack_bytes != '0) st_nxt.cons = sum_w[OFFSET_BITS-1:0];
        end
      end
      OP_CLEAR: begin
        res.status  = ST_DONE;
        st_nxt.cons = '0;
      end
      default: res.status = ST_RANGE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/dma_ring_consumer_window.sv -----
// Top level: DMA receive ring consumer window with config registers and result buffer.
//
// Usage:
//   in_ch  (valid/ready) carries poll, ack and clear words; out_ch returns exactly
//   one result word per input word, in order. cfg_we/cfg_index/cfg_data write
//   ring_bytes (index 0) and splice_bytes (index 1) while the block is idle;
//   other indexes are ignored.
// Timing:
//   Each word is evaluated against the ring state in the cycle it is accepted and
//   its result is registered in out_r, or in skid_r while out_r is held. Ring state
//   updates at the same edge, so words are accepted back to back, one per cycle,
//   while in_ch.ready is high; the poll compare/subtract and ack wrap set the period.
// Stall:
//   An output register plus a one-word skid register sit on the result side.
//   in_ch.ready drops only when both are full; it returns once out_ch takes a word.
// Reset:
//   Synchronous active-low rst_n clears consumer offset and last window, restores
//   ring_bytes = 16 MiB and splice_bytes = 8192, and empties the result buffer.
`default_nettype none
module dma_ring_consumer_window (
  input  logic                             clk,
  input  logic                             rst_n,
  drcw_in_if.sink                          in_ch,
  drcw_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [drcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [drcw_pkg::RING_W-1:0]      cfg_data
);
  import drcw_pkg::*;

  `include "dma_ring_consumer_window_assert.svh"

  logic [RING_W-1:0]   ring_bytes_r;
  logic [SPLICE_W-1:0] splice_bytes_r;
  ring_state_t         st_r;
  ring_state_t         st_nxt;
  item_t               item;
  result_t             res_nxt;
  result_t             out_r;
  result_t             skid_r;
  logic                out_valid_r;
  logic                skid_valid_r;
  logic                push;
  logic                pop;

  always_comb begin
    item.op              = in_ch.op;
    item.producer_offset = in_ch.producer_offset;
    item.message_flag    = in_ch.message_flag;
    item.reset_flag      = in_ch.reset_flag;
    item.stalled_flag    = in_ch.stalled_flag;
    item.overflow_flag   = in_ch.overflow_flag;
    item.ack_bytes       = in_ch.ack_bytes;
  end

  drcw_step u_step (
    .item         (item),
    .st           (st_r),
    .ring_bytes   (ring_bytes_r),
    .splice_bytes (splice_bytes_r),
    .res          (res_nxt),
    .st_nxt       (st_nxt)
  );

  assign in_ch.ready = !skid_valid_r;
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_bytes_r   <= RING_RESET;
      splice_bytes_r <= SPLICE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_RING_BYTES)   ring_bytes_r   <= cfg_data;
      if (cfg_index == REG_SPLICE_BYTES) splice_bytes_r <= cfg_data[SPLICE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (push) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) out_r <= skid_r;
    end else if (push) begin
      if (!out_valid_r || pop) out_r <= res_nxt;
      else                     skid_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_r.status;
  assign out_ch.from_splice   = out_r.from_splice;
  assign out_ch.window_offset = out_r.window_offset;
  assign out_ch.window_bytes  = out_r.window_bytes;
  assign out_ch.head_bytes    = out_r.head_bytes;
  assign out_ch.tail_bytes    = out_r.tail_bytes;

  `DRCW_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r, "skid word without output word")
  `DRCW_ASSERT_RST(a_reset_empty, !rst_n |=> (!out_valid_r && !skid_valid_r), "buffer not empty after reset")
  `DRCW_ASSERT(a_cons_hold, !push |=> $stable(st_r.cons), "consumer offset moved without a word")

endmodule
`default_nettype wire
